/* sv/ring_buffer_deque_engine_top_macros.svh */
// ----------------------------------------------------------------------------
// Ring buffer deque engine assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_ENGINE_TOP_MACROS_SVH
`define RING_BUFFER_DEQUE_ENGINE_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset
`define RBDE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset
`define RBDE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBDE_ASSERT_IMP(label, ante, cons, msg)
`define RBDE_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

/* sv/rbde_pkg.sv */
// ----------------------------------------------------------------------------
// Ring buffer deque engine package
// Sizes, operation and status codes, and beat and store request types.
// ----------------------------------------------------------------------------
package rbde_pkg;

  // Store geometry; slot arithmetic wraps naturally, so DEPTH is a power of two
  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int SLOT_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = 11;
  localparam int FUNC_BITS = 4;
  localparam int STAT_BITS = 2;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [FUNC_BITS-1:0] func_t;
  typedef logic [STAT_BITS-1:0] stat_t;

  // Operation codes
  localparam func_t FN_PUSH_FRONT = 4'd0;
  localparam func_t FN_PUSH_BACK  = 4'd1;
  localparam func_t FN_POP_FRONT  = 4'd2;
  localparam func_t FN_POP_BACK   = 4'd3;
  localparam func_t FN_GET        = 4'd4;
  localparam func_t FN_SET        = 4'd5;
  localparam func_t FN_INSERT     = 4'd6;
  localparam func_t FN_DELETE     = 4'd7;
  localparam func_t FN_FRONT      = 4'd8;
  localparam func_t FN_BACK       = 4'd9;
  localparam func_t FN_CLEAR      = 4'd10;

  // Status codes
  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_RANGE = 2'd1;
  localparam stat_t ST_FULL  = 2'd2;
  localparam stat_t ST_EMPTY = 2'd3;

  typedef struct packed {
    func_t func;
    cnt_t  position;
    word_t payload;
  } in_item_t;

  typedef struct packed {
    stat_t status;
    word_t read_word;
    logic  removed_valid;
    cnt_t  element_count;
  } out_item_t;

  // One write port and one read port into the slot store
  typedef struct packed {
    logic  we;
    slot_t waddr;
    word_t wdata;
    logic  re;
    slot_t raddr;
  } store_req_t;

endpackage

/* sv/ring_buffer_deque_engine_top.sv */
// ----------------------------------------------------------------------------
// Ring buffer deque engine
// Fixed-capacity double-ended queue of words in a circular slot store.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with one result beat. Push,
// set, clear, refused requests and pops on an empty queue load their result
// in the execute state; pop, get, front and back first wait on the
// registered read of the slot store. Insert and delete move the words on one
// side of the position one word per cycle through the store's single read
// and write port, at most half the count, rounded up. The input is ready
// again the cycle after a result beat is loaded; a held result beat stalls
// the finish of the next request. The store needs no clearing after reset.
`include "ring_buffer_deque_engine_top_macros.svh"

module ring_buffer_deque_engine_top import rbde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  cnt_t      cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_DCAP   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  in_item_t   req_r, req_nxt;
  cnt_t       cap_r, cap_nxt;
  slot_t      front_r, front_nxt;
  cnt_t       count_r, count_nxt;
  slot_t      src_r, src_nxt;
  slot_t      dst_r, dst_nxt;
  cnt_t       left_r, left_nxt;
  logic       asc_r, asc_nxt;
  logic       pend_r, pend_nxt;
  logic       side_r, side_nxt;
  word_t      word_r, word_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  store_req_t st_req;
  word_t      rd_data;
  out_item_t  res;
  logic       fin;
  logic       out_free;
  cnt_t       limit;
  logic       full;
  slot_t      pos_slot;
  slot_t      cnt_slot;
  logic       ins_front;
  logic       del_front;

  rbde_store u_store (
    .clk     (clk),
    .req     (st_req),
    .rd_data (rd_data)
  );

  // Effective limit and shift-side choice
  always_comb begin
    limit     = (cap_r > cnt_t'(DEPTH)) ? cnt_t'(DEPTH) : cap_r;
    full      = (count_r >= limit);
    pos_slot  = req_r.position[SLOT_BITS-1:0];
    cnt_slot  = count_r[SLOT_BITS-1:0];
    out_free  = !out_valid_r || out_ready;
    ins_front = (req_r.position != count_r) &&
                ((req_r.position == '0) || (req_r.position < (count_r >> 1)));
    del_front = (req_r.position != (count_r - cnt_t'(1))) &&
                ((req_r.position == '0) || (req_r.position < (count_r >> 1)));
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    left_nxt      = left_r;
    asc_nxt       = asc_r;
    pend_nxt      = pend_r;
    side_nxt      = side_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    st_req        = '0;
    res           = '0;
    fin           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req_r.func)
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (out_free) begin
              fin = 1'b1;
              if (full) begin
                res.status = ST_FULL;
              end else begin
                st_req.we    = 1'b1;
                st_req.wdata = req_r.payload;
                if (req_r.func == FN_PUSH_FRONT) begin
                  st_req.waddr = front_r - slot_t'(1);
                  front_nxt    = front_r - slot_t'(1);
                end else begin
                  st_req.waddr = front_r + cnt_slot;
                end
                count_nxt = count_r + cnt_t'(1);
              end
            end
          end
          FN_POP_FRONT, FN_POP_BACK: begin
            if (count_r == '0) begin
              fin = out_free;
            end else begin
              st_req.re    = 1'b1;
              st_req.raddr = (req_r.func == FN_POP_FRONT) ? front_r :
                             front_r + cnt_slot - slot_t'(1);
              state_nxt    = S_RDWAIT;
            end
          end
          FN_GET: begin
            if (req_r.position >= count_r) begin
              fin        = out_free;
              res.status = ST_RANGE;
            end else begin
              st_req.re    = 1'b1;
              st_req.raddr = front_r + pos_slot;
              state_nxt    = S_RDWAIT;
            end
          end
          FN_SET: begin
            if (out_free) begin
              fin = 1'b1;
              if (req_r.position >= count_r) begin
                res.status = ST_RANGE;
              end else begin
                st_req.we    = 1'b1;
                st_req.waddr = front_r + pos_slot;
                st_req.wdata = req_r.payload;
              end
            end
          end
          FN_INSERT: begin
            if (req_r.position > count_r) begin
              fin        = out_free;
              res.status = ST_RANGE;
            end else if (full) begin
              fin        = out_free;
              res.status = ST_FULL;
            end else begin
              // Front side slides down by one, back side slides up by one
              side_nxt = ins_front;
              pend_nxt = 1'b0;
              if (ins_front) begin
                src_nxt  = front_r;
                left_nxt = req_r.position;
                asc_nxt  = 1'b1;
              end else begin
                src_nxt  = front_r + cnt_slot - slot_t'(1);
                left_nxt = count_r - req_r.position;
                asc_nxt  = 1'b0;
              end
              state_nxt = S_SHIFT;
            end
          end
          FN_DELETE: begin
            if (req_r.position >= count_r) begin
              fin        = out_free;
              res.status = ST_RANGE;
            end else begin
              // Fetch the victim first, then close the gap
              st_req.re    = 1'b1;
              st_req.raddr = front_r + pos_slot;
              side_nxt     = del_front;
              pend_nxt     = 1'b0;
              if (del_front) begin
                src_nxt  = front_r + pos_slot - slot_t'(1);
                left_nxt = req_r.position;
                asc_nxt  = 1'b0;
              end else begin
                src_nxt  = front_r + pos_slot + slot_t'(1);
                left_nxt = count_r - cnt_t'(1) - req_r.position;
                asc_nxt  = 1'b1;
              end
              state_nxt = S_DCAP;
            end
          end
          FN_FRONT, FN_BACK: begin
            if (count_r == '0) begin
              fin        = out_free;
              res.status = ST_EMPTY;
            end else begin
              st_req.re    = 1'b1;
              st_req.raddr = (req_r.func == FN_FRONT) ? front_r :
                             front_r + cnt_slot - slot_t'(1);
              state_nxt    = S_RDWAIT;
            end
          end
          FN_CLEAR: begin
            if (out_free) begin
              fin       = 1'b1;
              count_nxt = '0;
              front_nxt = '0;
            end
          end
          default: begin
            fin = out_free;
          end
        endcase
      end

      S_RDWAIT: begin
        if (out_free) begin
          fin           = 1'b1;
          res.read_word = rd_data;
          if ((req_r.func == FN_POP_FRONT) || (req_r.func == FN_POP_BACK)) begin
            res.removed_valid = 1'b1;
            count_nxt         = count_r - cnt_t'(1);
            if (req_r.func == FN_POP_FRONT) begin
              front_nxt = front_r + slot_t'(1);
            end
          end
        end
      end

      S_DCAP: begin
        word_nxt  = rd_data;
        state_nxt = S_SHIFT;
      end

      S_SHIFT: begin
        // Drain the word read last cycle, read the next one
        if (pend_r) begin
          st_req.we    = 1'b1;
          st_req.waddr = dst_r;
          st_req.wdata = rd_data;
        end
        if (left_r != '0) begin
          st_req.re    = 1'b1;
          st_req.raddr = src_r;
          dst_nxt      = asc_r ? src_r - slot_t'(1) : src_r + slot_t'(1);
          src_nxt      = asc_r ? src_r + slot_t'(1) : src_r - slot_t'(1);
          left_nxt     = left_r - cnt_t'(1);
          pend_nxt     = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        if (out_free) begin
          fin = 1'b1;
          if (req_r.func == FN_INSERT) begin
            st_req.we    = 1'b1;
            st_req.waddr = front_r + pos_slot - slot_t'(side_r);
            st_req.wdata = req_r.payload;
            front_nxt    = side_r ? front_r - slot_t'(1) : front_r;
            count_nxt    = count_r + cnt_t'(1);
          end else begin
            res.removed_valid = 1'b1;
            res.read_word     = word_r;
            front_nxt         = side_r ? front_r + slot_t'(1) : front_r;
            count_nxt         = count_r - cnt_t'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the result beat or drop a taken one
    res.element_count = count_nxt;
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
      state_nxt     = S_IDLE;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= cnt_t'(DEPTH);
      front_r     <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and working registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    left_r <= left_nxt;
    asc_r  <= asc_nxt;
    side_r <= side_nxt;
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Count moves by at most one per request, or drops to zero on clear
  `RBDE_ASSERT_NXT(a_count_step, 1'b1, (count_r == $past(count_r)) || (count_r == $past(count_r) + cnt_t'(1)) || (count_r == $past(count_r) - cnt_t'(1)) || (count_r == '0), "count jumped")
  // Queue pointers hold while waiting for a request
  `RBDE_ASSERT_NXT(a_idle_hold, state_r == S_IDLE, $stable(front_r) && $stable(count_r), "pointers moved while idle")
  // No store write while idle
  `RBDE_ASSERT_IMP(a_idle_nowr, state_r == S_IDLE, !st_req.we, "store written while idle")
  // A pending shift write exists only inside the shift loop
  `RBDE_ASSERT_IMP(a_pend_shift, pend_r, state_r == S_SHIFT, "shift write pending outside loop")

endmodule

/* sv/rbde_store.sv */
// ----------------------------------------------------------------------------
// Ring buffer deque slot store
// Single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rbde_store import rbde_pkg::*; (
  input  logic       clk,
  input  store_req_t req,
  output word_t      rd_data
);

  word_t mem [DEPTH];
  word_t rd_data_r;

  // Write one slot
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read one slot, hold data until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer deque engine testbench
// Drives requests through the valid/ready input channel and compares every
// result beat against an in-bench deque predictor. It covers all operations,
// empty and full queues, index errors, shifts on either side and several
// capacity settings, with random gaps and a long result-side stall.
// ----------------------------------------------------------------------------
module tb import rbde_pkg::*; ();

  // Code outside the defined operation set
  localparam func_t FN_UNUSED_TOP = 4'hF;

  // Track queue contents and queue up the expected result beats
  class deque_scoreboard;
    word_t       slots [DEPTH];
    slot_t       head;
    cnt_t        count;
    cnt_t        cap;
    out_item_t   pending [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned requests;
    int unsigned peak;
    int unsigned full_refusals;
    int unsigned range_refusals;
    int unsigned removals;

    function new();
      head  = '0;
      count = '0;
      cap   = cnt_t'(DEPTH);
    endfunction

    function void set_capacity(cnt_t value);
      cap = value;
    endfunction

    function slot_t slot_at(int unsigned k);
      return slot_t'(head + k);
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(in_item_t item);
      out_item_t   exp;
      int unsigned n;
      int unsigned pos;
      int unsigned lim;
      int unsigned k;
      logic        full;
      n    = count;
      pos  = item.position;
      lim  = (cap > DEPTH) ? DEPTH : cap;
      full = (n >= lim);
      exp  = '0;
      requests++;
      case (item.func)
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (full) begin
            exp.status = ST_FULL;
          end else begin
            if (item.func == FN_PUSH_FRONT) begin
              head = head - 1'b1;
              slots[head] = item.payload;
            end else begin
              slots[slot_at(n)] = item.payload;
            end
            n++;
          end
        end
        FN_POP_FRONT, FN_POP_BACK: begin
          if (n != 0) begin
            exp.removed_valid = 1'b1;
            if (item.func == FN_POP_FRONT) begin
              exp.read_word = slots[head];
              head = head + 1'b1;
            end else begin
              exp.read_word = slots[slot_at(n - 1)];
            end
            n--;
          end
        end
        FN_GET: begin
          if (pos >= n) exp.status = ST_RANGE;
          else exp.read_word = slots[slot_at(pos)];
        end
        FN_SET: begin
          if (pos >= n) exp.status = ST_RANGE;
          else slots[slot_at(pos)] = item.payload;
        end
        FN_INSERT: begin
          if (pos > n) begin
            exp.status = ST_RANGE;
          end else if (full) begin
            exp.status = ST_FULL;
          end else begin
            // Open a gap: the front side moves when pos is zero or below n / 2 (and not n), else the back side
            if (pos != n && (pos == 0 || pos < n / 2)) begin
              head = head - 1'b1;
              for (k = 0; k < pos; k++) slots[slot_at(k)] = slots[slot_at(k + 1)];
            end else begin
              for (k = n; k > pos; k--) slots[slot_at(k)] = slots[slot_at(k - 1)];
            end
            slots[slot_at(pos)] = item.payload;
            n++;
          end
        end
        FN_DELETE: begin
          if (pos >= n) begin
            exp.status = ST_RANGE;
          end else begin
            exp.removed_valid = 1'b1;
            exp.read_word = slots[slot_at(pos)];
            // Close the gap: the front side moves when pos is zero or below n / 2 (and not n - 1), else the back side
            if (pos != n - 1 && (pos == 0 || pos < n / 2)) begin
              for (k = pos; k > 0; k--) slots[slot_at(k)] = slots[slot_at(k - 1)];
              head = head + 1'b1;
            end else begin
              for (k = pos; k + 1 < n; k++) slots[slot_at(k)] = slots[slot_at(k + 1)];
            end
            n--;
          end
        end
        FN_FRONT, FN_BACK: begin
          if (n == 0) exp.status = ST_EMPTY;
          else exp.read_word = slots[(item.func == FN_FRONT) ? head : slot_at(n - 1)];
        end
        FN_CLEAR: begin
          n    = 0;
          head = '0;
        end
        default: ;
      endcase
      if (exp.status == ST_FULL) full_refusals++;
      if (exp.status == ST_RANGE) range_refusals++;
      if (exp.removed_valid) removals++;
      count = cnt_t'(n);
      if (n > peak) peak = n;
      exp.element_count = count;
      pending.push_back(exp);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] result %0d mismatch: %s", $time, checked, what);
    endtask

    // Compare one result beat against the oldest expectation
    task check_result(out_item_t got);
      out_item_t exp;
      checked++;
      if (pending.size() == 0) begin
        report("result beat with no request outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.read_word !== exp.read_word)
        report($sformatf("read_word %h, expected %h", got.read_word, exp.read_word));
      if (got.removed_valid !== exp.removed_valid)
        report($sformatf("removed_valid %b, expected %b",
                         got.removed_valid, exp.removed_valid));
      if (got.element_count !== exp.element_count)
        report($sformatf("element_count %0d, expected %0d",
                         got.element_count, exp.element_count));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  cnt_t      cfg_wdata = '0;

  deque_scoreboard sb = new();
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned n_settings = 0;

  ring_buffer_deque_engine_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request beat, hold it until accepted, then record it
  task automatic send_item(in_item_t item);
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_request(item);
  endtask

  task automatic issue(func_t f, int unsigned pos, word_t w);
    in_item_t item;
    item.func     = f;
    item.position = cnt_t'(pos);
    item.payload  = w;
    send_item(item);
  endtask

  // Drain outstanding results, then write the capacity register
  task automatic write_capacity(cnt_t value);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(value);
    n_settings++;
  endtask

  // Pick an index: mostly legal, with the ends and one past the end favored
  function automatic cnt_t pick_index(int unsigned span);
    if (span == 0) return '0;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return cnt_t'(span - 1);
      2:       return cnt_t'(span);
      default: return cnt_t'($urandom_range(0, span - 1));
    endcase
  endfunction

  // Build a request from the current queue state; grow_pct steers the fill level
  function automatic in_item_t pick_request(int unsigned grow_pct);
    in_item_t    item;
    int unsigned n;
    int unsigned r;
    n    = sb.count;
    item = '0;
    item.payload = ($urandom_range(0, 15) == 0) ?
                   ($urandom_range(0, 1) ? '1 : '0) : word_t'($urandom);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // Noise: any code, any index; clear becomes back above 60 percent growth
      item.func     = func_t'($urandom_range(0, 15));
      item.position = cnt_t'($urandom_range(0, 2047));
      if (item.func == FN_CLEAR && grow_pct > 60) item.func = FN_BACK;
    end else if (r < 4 + grow_pct) begin
      case ($urandom_range(0, 2))
        0: item.func = FN_PUSH_FRONT;
        1: item.func = FN_PUSH_BACK;
        default: begin
          item.func     = FN_INSERT;
          item.position = pick_index(n + 1);
        end
      endcase
    end else begin
      case ($urandom_range(0, 6))
        0: item.func = FN_POP_FRONT;
        1: item.func = FN_POP_BACK;
        2: item.func = FN_DELETE;
        3: item.func = FN_GET;
        4: item.func = FN_SET;
        5: item.func = FN_FRONT;
        default: item.func = FN_BACK;
      endcase
      item.position = pick_index(n);
    end
    return item;
  endfunction

  task automatic run_mix(int unsigned grow_pct, int unsigned n_items, bit no_idle,
                         int hold_at);
    steady = no_idle;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_item(pick_request(grow_pct));
    end
  endtask

  // Result side: check each beat, stall at random or on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_capacity(cnt_t'(DEPTH));

    // Empty queue: reads, pops and index errors
    issue(FN_FRONT, 0, '0);
    issue(FN_BACK, 0, '0);
    issue(FN_POP_FRONT, 0, '0);
    issue(FN_POP_BACK, 0, '0);
    issue(FN_GET, 2047, '0);
    issue(FN_DELETE, 0, '0);
    issue(FN_INSERT, 1, '0);
    // Build a few words; the front push wraps the head below slot zero
    issue(FN_INSERT, 0, 32'h0000_0001);
    issue(FN_PUSH_FRONT, 0, 32'hFFFF_FFFF);
    issue(FN_PUSH_BACK, 0, 32'h0000_0000);
    issue(FN_PUSH_BACK, 0, 32'h1234_5678);
    issue(FN_SET, 1, 32'hA5A5_5A5A);
    issue(FN_GET, 1, '0);
    // Inserts moving the back side, the front side, and appending
    issue(FN_INSERT, 2, 32'h2222_2222);
    issue(FN_INSERT, 1, 32'h3333_3333);
    issue(FN_INSERT, 6, 32'h4444_4444);
    // Deletes from the front side, the back side and the head
    issue(FN_DELETE, 1, '0);
    issue(FN_DELETE, 4, '0);
    issue(FN_DELETE, 0, '0);
    issue(FN_FRONT, 0, '0);
    issue(FN_BACK, 0, '0);
    issue(FN_UNUSED_TOP, 2047, 32'hFFFF_FFFF);
    issue(FN_POP_FRONT, 0, '0);
    issue(FN_POP_BACK, 0, '0);
    issue(FN_CLEAR, 0, '0);
    // Zero capacity refuses growth; the index check still comes first
    write_capacity('0);
    issue(FN_PUSH_BACK, 0, 32'hDEAD_0001);
    issue(FN_INSERT, 0, 32'hDEAD_0002);
    issue(FN_INSERT, 1, 32'hDEAD_0003);

    // Random mixes; the first one carries the long result-side stall
    write_capacity(cnt_t'(DEPTH));
    run_mix(50, 200, 1'b0, 80);
    write_capacity(cnt_t'(1));
    issue(FN_CLEAR, 0, '0);
    run_mix(50, 80, 1'b0, -1);
    write_capacity(cnt_t'(2));
    run_mix(50, 80, 1'b0, -1);
    write_capacity(cnt_t'(9));
    run_mix(55, 60, 1'b1, -1);

    // Fill to the full store, then work at the top
    write_capacity(cnt_t'(DEPTH));
    steady = 1'b0;
    while (sb.count < DEPTH) send_item(pick_request(95));
    run_mix(45, 16, 1'b0, -1);

    // Capacity now below the count: growth refused while draining
    write_capacity(cnt_t'(300));
    run_mix(30, 100, 1'b0, -1);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests across %0d capacity settings; %0d result beats checked.",
             sb.requests, n_settings, sb.checked);
    $display("Peak count %0d, %0d full refusals, %0d index errors, %0d removals.",
             sb.peak, sb.full_refusals, sb.range_refusals, sb.removals);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #50000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/rbde_pkg.sv
sv/rbde_store.sv
sv/ring_buffer_deque_engine_top.sv
test/tb.sv
